[rtl/greedy_polyline_chainer_macros.svh]
// ----------------------------------------------------------------------------
// Chainer assertion macros
// Assertion macros used by the chainer top module.
// ----------------------------------------------------------------------------
`ifndef GREEDY_POLYLINE_CHAINER_MACROS_SVH
`define GREEDY_POLYLINE_CHAINER_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define GPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that implies a consequence in the next cycle.
`define GPC_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chainer package
// Shared constants, the sequencer states and the cell control bundle.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int MAX_TRAJ   = 64;
  localparam int COORD_BITS = 12;
  localparam int DIST_W     = 16;
  localparam int GRP_W      = 6;
  localparam int IDX_OUT_W  = 6;
  localparam logic [DIST_W-1:0] DIST_RESET = 16'd10;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FIRST,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic load;
    logic rotate;
    logic clear;
    logic mark;
  } cell_ctrl_t;

endpackage

[rtl/gpc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chainer channels
// Input channel of polyline end points and output channel of ordering beats.
// ----------------------------------------------------------------------------
interface gpc_in_if;
  logic                           valid;
  logic                           ready;
  logic [gpc_pkg::COORD_BITS-1:0] start_x;
  logic [gpc_pkg::COORD_BITS-1:0] start_y;
  logic [gpc_pkg::COORD_BITS-1:0] end_x;
  logic [gpc_pkg::COORD_BITS-1:0] end_y;
  logic                           last_item;

  modport source (output valid, start_x, start_y, end_x, end_y, last_item, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, last_item, output ready);
endinterface

interface gpc_out_if;
  logic                           valid;
  logic                           ready;
  logic [gpc_pkg::IDX_OUT_W-1:0]  traj_index;
  logic                           reversed;
  logic                           new_group;
  logic [gpc_pkg::GRP_W-1:0]      group_index;
  logic                           last_result;

  modport source (output valid, traj_index, reversed, new_group, group_index, last_result,
                  input ready);
  modport sink   (input valid, traj_index, reversed, new_group, group_index, last_result,
                  output ready);
endinterface

[rtl/gpc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chainer cell
// Holds one polyline's end points, its load index and its taken flag, and
// passes them to its neighbour while the ring rotates.
// ----------------------------------------------------------------------------
module gpc_cell #(
  parameter int COORD_BITS = gpc_pkg::COORD_BITS,
  parameter int IDXW       = 6,
  parameter int POS        = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gpc_pkg::cell_ctrl_t   ctrl_i,
  input  logic [IDXW-1:0]       mark_idx_i,
  input  logic [COORD_BITS-1:0] wr_sx_i,
  input  logic [COORD_BITS-1:0] wr_sy_i,
  input  logic [COORD_BITS-1:0] wr_ex_i,
  input  logic [COORD_BITS-1:0] wr_ey_i,
  input  logic [COORD_BITS-1:0] nb_sx_i,
  input  logic [COORD_BITS-1:0] nb_sy_i,
  input  logic [COORD_BITS-1:0] nb_ex_i,
  input  logic [COORD_BITS-1:0] nb_ey_i,
  input  logic [IDXW-1:0]       nb_idx_i,
  input  logic                  nb_taken_i,
  output logic [COORD_BITS-1:0] sx_o,
  output logic [COORD_BITS-1:0] sy_o,
  output logic [COORD_BITS-1:0] ex_o,
  output logic [COORD_BITS-1:0] ey_o,
  output logic [IDXW-1:0]       idx_o,
  output logic                  taken_o
);

  logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [IDXW-1:0]       idx_q;
  logic                  taken_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rotate) begin
      sx_q <= nb_sx_i;
      sy_q <= nb_sy_i;
      ex_q <= nb_ex_i;
      ey_q <= nb_ey_i;
    end else if (ctrl_i.load) begin
      sx_q <= wr_sx_i;
      sy_q <= wr_sy_i;
      ex_q <= wr_ex_i;
      ey_q <= wr_ey_i;
    end
  end

  // The index restarts at the cell's own place and returns there after a full turn.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= IDXW'(POS);
      taken_q <= 1'b0;
    end else if (ctrl_i.rotate) begin
      idx_q   <= nb_idx_i;
      taken_q <= nb_taken_i;
    end else if (ctrl_i.clear || ctrl_i.load) begin
      taken_q <= 1'b0;
    end else if (ctrl_i.mark && idx_q == mark_idx_i) begin
      taken_q <= 1'b1;
    end
  end

  assign sx_o    = sx_q;
  assign sy_o    = sy_q;
  assign ex_o    = ex_q;
  assign ey_o    = ey_q;
  assign idx_o   = idx_q;
  assign taken_o = taken_q;

endmodule

[rtl/greedy_polyline_chainer.sv]
`timescale 1ns / 1ps
// Loading takes one beat per cycle while no result is pending. After the last beat the
// ST_FIRST state emits the first result. Each later result takes a full turn of the cell
// ring past the distance pipeline, a drain of the pipeline, a decision state and a
// hand-over state that waits until the output register is free.
// Reset is asynchronous, active low; it clears counts and flags, stores are not cleared.
// ----------------------------------------------------------------------------
// Greedy polyline chainer
// Orders loaded polylines by nearest tail-to-end-point distance using a rotating
// ring of cells and a pipelined squared-distance unit at the head of the ring.
// ----------------------------------------------------------------------------
`include "greedy_polyline_chainer_macros.svh"

module greedy_polyline_chainer #(
  parameter int MAX_TRAJ   = gpc_pkg::MAX_TRAJ
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gpc_pkg::DIST_W-1:0] cfg_wdata_i,
  gpc_in_if.sink                     in_if,
  gpc_out_if.source                  out_if
);

  localparam int COORD_BITS = gpc_pkg::COORD_BITS;
  localparam int IDXW = $clog2(MAX_TRAJ);
  localparam int CNTW = $clog2(MAX_TRAJ + 1);
  localparam int SQW  = 2 * COORD_BITS;
  localparam int D2W  = SQW + 1;
  localparam int LW   = 2 * gpc_pkg::DIST_W;
  localparam int CW   = (D2W > LW) ? D2W : LW;

  gpc_pkg::state_e state_q, state_d;

  logic [gpc_pkg::DIST_W-1:0] dist_q;
  logic [LW-1:0]              lim_q;
  logic [CNTW-1:0]            cnt_q, emit_q;
  logic [IDXW-1:0]            rot_q;
  logic                       drain_q;
  logic [COORD_BITS-1:0]      tail_x_q, tail_y_q;
  logic [gpc_pkg::GRP_W-1:0]  grp_q;

  gpc_pkg::cell_ctrl_t        ctrl [MAX_TRAJ];
  logic                       load_c, rotate_c, clear_c, mark_c;
  logic [IDXW-1:0]            mark_idx_c;

  logic [COORD_BITS-1:0] c_sx [MAX_TRAJ];
  logic [COORD_BITS-1:0] c_sy [MAX_TRAJ];
  logic [COORD_BITS-1:0] c_ex [MAX_TRAJ];
  logic [COORD_BITS-1:0] c_ey [MAX_TRAJ];
  logic [IDXW-1:0]       c_idx [MAX_TRAJ];
  logic                  c_taken [MAX_TRAJ];

  for (genvar p = 0; p < MAX_TRAJ; p++) begin : g_cell
    localparam int NXT = (p + 1) % MAX_TRAJ;
    always_comb begin
      ctrl[p].load   = load_c && (cnt_q == CNTW'(p));
      ctrl[p].rotate = rotate_c;
      ctrl[p].clear  = clear_c;
      ctrl[p].mark   = mark_c;
    end
    gpc_cell #(.COORD_BITS(COORD_BITS), .IDXW(IDXW), .POS(p)) u_cell (
      .clk_i, .rst_ni,
      .ctrl_i     (ctrl[p]),
      .mark_idx_i (mark_idx_c),
      .wr_sx_i    (in_if.start_x),
      .wr_sy_i    (in_if.start_y),
      .wr_ex_i    (in_if.end_x),
      .wr_ey_i    (in_if.end_y),
      .nb_sx_i    (c_sx[NXT]),
      .nb_sy_i    (c_sy[NXT]),
      .nb_ex_i    (c_ex[NXT]),
      .nb_ey_i    (c_ey[NXT]),
      .nb_idx_i   (c_idx[NXT]),
      .nb_taken_i (c_taken[NXT]),
      .sx_o       (c_sx[p]),
      .sy_o       (c_sy[p]),
      .ex_o       (c_ex[p]),
      .ey_o       (c_ey[p]),
      .idx_o      (c_idx[p]),
      .taken_o    (c_taken[p])
    );
  end

  // Configuration and squared threshold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= gpc_pkg::DIST_RESET;
    end else if (cfg_we_i) begin
      dist_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= dist_q * dist_q;
  end

  // Distance pipeline at the head of the ring.
  logic                  s1_v_q, s2_v_q;
  logic [COORD_BITS-1:0] s1_dsx_q, s1_dsy_q, s1_dex_q, s1_dey_q;
  logic [COORD_BITS-1:0] s1_sx_q, s1_sy_q, s1_ex_q, s1_ey_q;
  logic [IDXW-1:0]       s1_idx_q, s2_idx_q;
  logic [SQW-1:0]        s2_ssx_q, s2_ssy_q, s2_sex_q, s2_sey_q;
  logic [COORD_BITS-1:0] s2_sx_q, s2_sy_q, s2_ex_q, s2_ey_q;

  function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  logic head_elig;
  assign head_elig = rotate_c && !c_taken[0] && ({1'b0, c_idx[0]} < (IDXW+1)'(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= head_elig;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dsx_q <= absdiff(tail_x_q, c_sx[0]);
    s1_dsy_q <= absdiff(tail_y_q, c_sy[0]);
    s1_dex_q <= absdiff(tail_x_q, c_ex[0]);
    s1_dey_q <= absdiff(tail_y_q, c_ey[0]);
    s1_sx_q  <= c_sx[0];
    s1_sy_q  <= c_sy[0];
    s1_ex_q  <= c_ex[0];
    s1_ey_q  <= c_ey[0];
    s1_idx_q <= c_idx[0];
    s2_ssx_q <= s1_dsx_q * s1_dsx_q;
    s2_ssy_q <= s1_dsy_q * s1_dsy_q;
    s2_sex_q <= s1_dex_q * s1_dex_q;
    s2_sey_q <= s1_dey_q * s1_dey_q;
    s2_sx_q  <= s1_sx_q;
    s2_sy_q  <= s1_sy_q;
    s2_ex_q  <= s1_ex_q;
    s2_ey_q  <= s1_ey_q;
    s2_idx_q <= s1_idx_q;
  end

  // Best-candidate tracker; start point is tried before end point.
  logic                  found_q, found_d;
  logic [D2W-1:0]        best_q, best_d, ds_c, de_c;
  logic [IDXW-1:0]       bidx_q, bidx_d;
  logic                  brev_q, brev_d;
  logic [COORD_BITS-1:0] far_x_q, far_x_d, far_y_q, far_y_d;
  logic                  scan_start_c;

  always_comb begin
    ds_c    = D2W'(s2_ssx_q) + D2W'(s2_ssy_q);
    de_c    = D2W'(s2_sex_q) + D2W'(s2_sey_q);
    found_d = found_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    brev_d  = brev_q;
    far_x_d = far_x_q;
    far_y_d = far_y_q;
    if (s2_v_q) begin
      if (!found_d || ds_c < best_d) begin
        found_d = 1'b1;
        best_d  = ds_c;
        bidx_d  = s2_idx_q;
        brev_d  = 1'b0;
        far_x_d = s2_ex_q;
        far_y_d = s2_ey_q;
      end
      if (de_c < best_d) begin
        best_d  = de_c;
        bidx_d  = s2_idx_q;
        brev_d  = 1'b1;
        far_x_d = s2_sx_q;
        far_y_d = s2_sy_q;
      end
    end
    if (scan_start_c) begin
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    bidx_q  <= bidx_d;
    brev_q  <= brev_d;
    far_x_q <= far_x_d;
    far_y_q <= far_y_d;
  end

  // Output register.
  logic                      out_v_q;
  logic [IDXW-1:0]           o_idx_q;
  logic                      o_rev_q, o_newg_q, o_last_q;
  logic [gpc_pkg::GRP_W-1:0] o_grp_q;
  logic                      emit_c, in_acc, out_acc, far_c;
  logic [IDXW-1:0]           e_idx_c;
  logic                      e_rev_c, e_newg_c;
  logic [gpc_pkg::GRP_W-1:0] e_grp_c;
  logic [COORD_BITS-1:0]     e_tx_c, e_ty_c;

  assign in_if.ready = (state_q == gpc_pkg::ST_LOAD) && !out_v_q;
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_acc     = out_v_q && out_if.ready;
  assign far_c       = !(CW'(best_q) < CW'(lim_q));

  always_comb begin
    state_d      = state_q;
    load_c       = 1'b0;
    rotate_c     = 1'b0;
    clear_c      = 1'b0;
    mark_c       = 1'b0;
    mark_idx_c   = bidx_q;
    scan_start_c = 1'b0;
    emit_c       = 1'b0;
    e_idx_c      = bidx_q;
    e_rev_c      = brev_q;
    e_newg_c     = far_c;
    e_grp_c      = far_c ? grp_q + 1'b1 : grp_q;
    e_tx_c       = far_x_q;
    e_ty_c       = far_y_q;
    unique case (state_q)
      gpc_pkg::ST_LOAD: begin
        if (in_acc) begin
          load_c = (cnt_q < CNTW'(MAX_TRAJ));
          if (in_if.last_item) begin
            state_d = gpc_pkg::ST_FIRST;
          end
        end
      end
      gpc_pkg::ST_FIRST: begin
        emit_c     = 1'b1;
        mark_c     = 1'b1;
        mark_idx_c = '0;
        e_idx_c    = '0;
        e_rev_c    = 1'b0;
        e_newg_c   = 1'b1;
        e_grp_c    = '0;
        e_tx_c     = c_ex[0];
        e_ty_c     = c_ey[0];
        state_d    = gpc_pkg::ST_WAIT;
      end
      gpc_pkg::ST_SCAN: begin
        rotate_c = 1'b1;
        if (rot_q == IDXW'(MAX_TRAJ - 1)) begin
          state_d = gpc_pkg::ST_DRAIN;
        end
      end
      gpc_pkg::ST_DRAIN: begin
        if (drain_q) begin
          state_d = gpc_pkg::ST_DECIDE;
        end
      end
      gpc_pkg::ST_DECIDE: begin
        emit_c  = 1'b1;
        mark_c  = 1'b1;
        state_d = gpc_pkg::ST_WAIT;
      end
      gpc_pkg::ST_WAIT: begin
        if (!out_v_q) begin
          if (emit_q == cnt_q) begin
            clear_c = 1'b1;
            state_d = gpc_pkg::ST_LOAD;
          end else begin
            scan_start_c = 1'b1;
            state_d      = gpc_pkg::ST_SCAN;
          end
        end
      end
      default: state_d = gpc_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gpc_pkg::ST_LOAD;
      cnt_q    <= '0;
      emit_q   <= '0;
      rot_q    <= '0;
      drain_q  <= 1'b0;
      tail_x_q <= '0;
      tail_y_q <= '0;
      grp_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_c) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (clear_c) begin
        cnt_q  <= '0;
        emit_q <= '0;
        grp_q  <= '0;
      end
      rot_q   <= rotate_c ? rot_q + 1'b1 : '0;
      drain_q <= (state_q == gpc_pkg::ST_DRAIN) ? !drain_q : 1'b0;
      if (out_acc) begin
        out_v_q <= 1'b0;
      end
      if (emit_c) begin
        out_v_q  <= 1'b1;
        emit_q   <= emit_q + 1'b1;
        tail_x_q <= e_tx_c;
        tail_y_q <= e_ty_c;
        grp_q    <= e_grp_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_c) begin
      o_idx_q  <= e_idx_c;
      o_rev_q  <= e_rev_c;
      o_newg_q <= e_newg_c;
      o_grp_q  <= e_grp_c;
      o_last_q <= (emit_q + 1'b1) == cnt_q;
    end
  end

  assign out_if.valid       = out_v_q;
  assign out_if.traj_index  = gpc_pkg::IDX_OUT_W'(o_idx_q);
  assign out_if.reversed    = o_rev_q;
  assign out_if.new_group   = o_newg_q;
  assign out_if.group_index = o_grp_q;
  assign out_if.last_result = o_last_q;

  `GPC_ASSERT(a_no_overlap, !(in_if.ready && out_if.valid), "input open while result pending")
  `GPC_ASSERT(a_cnt_range, cnt_q <= CNTW'(MAX_TRAJ), "polyline count beyond store")
  `GPC_ASSERT(a_emit_range, emit_q <= cnt_q, "more results than polylines")
  `GPC_ASSERT_NEXT(a_last_clears, out_acc && o_last_q, emit_q == cnt_q, "count lost at end")

endmodule
